// ===== hw/rtl/api_frame_deframer_assert.svh =====
// Assertion macros used by the checker module.
`ifndef API_FRAME_DEFRAMER_ASSERT_SVH
`define API_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define AFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("api_frame_deframer assertion failed");

// Next-cycle implication, disabled during reset.
`define AFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("api_frame_deframer assertion failed");

`endif

// ===== hw/rtl/afd_pkg.sv =====
package afd_pkg;

    localparam int unsigned BUF_BYTES_DEF = 128;

    localparam logic [7:0] DELIM    = 8'h7E;
    localparam logic [7:0] SUM_GOOD = 8'hFF;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned INDEX_W  = 7;
    localparam int unsigned LENGTH_W = 16;
    localparam int unsigned STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE = 3'd0,
        ST_BODY = 3'd1,
        ST_GOOD = 3'd2,
        ST_BAD  = 3'd3,
        ST_OVER = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY
    } t_phase;

endpackage

// ===== hw/rtl/api_frame_deframer.sv =====
// Length-prefixed frame deframer with 8-bit additive checksum.
// The result beat of an accepted rx beat appears in the output register in the next cycle.
// Throughput: 1 rx beat per cycle unless a held result waits; the output register lets
// a new beat in while the held result is taken in the same cycle.
// Reset: synchronous, active low; clears the phase to hunting and empties the
// output register.
module api_frame_deframer #(
    parameter int unsigned BUF_BYTES = afd_pkg::BUF_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rx_valid,
    output logic                          o_rx_ready,
    input  logic [afd_pkg::DATA_W-1:0]    i_rx_byte,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [afd_pkg::STATUS_W-1:0]  o_status,
    output logic [afd_pkg::DATA_W-1:0]    o_data_byte,
    output logic [afd_pkg::INDEX_W-1:0]   o_byte_index,
    output logic [afd_pkg::LENGTH_W-1:0]  o_frame_length
);

    localparam int unsigned IDX_W = $clog2(BUF_BYTES + 1);

    afd_pkg::t_phase                  r_phase, n_phase;
    logic [afd_pkg::DATA_W-1:0]       r_len_hi, n_len_hi;
    logic [afd_pkg::LENGTH_W-1:0]     r_len, n_len;
    logic [afd_pkg::DATA_W-1:0]       r_sum, n_sum;
    logic [IDX_W-1:0]                 r_idx, n_idx;

    logic                             r_valid;
    afd_pkg::t_status                 r_status, n_status;
    logic [afd_pkg::DATA_W-1:0]       r_data, n_data;
    logic [afd_pkg::INDEX_W-1:0]      r_index, n_index;
    logic [afd_pkg::LENGTH_W-1:0]     r_flen, n_flen;

    logic                             rx_acc;

    assign o_rx_ready = !r_valid || i_res_ready;
    assign rx_acc     = i_rx_valid && o_rx_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= afd_pkg::PH_HUNT;
        end else if (rx_acc) begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_len_hi = r_len_hi;
        n_len    = r_len;
        n_sum    = r_sum;
        n_idx    = r_idx;
        n_status = afd_pkg::ST_NONE;
        n_data   = '0;
        n_index  = '0;
        n_flen   = '0;
        unique case (r_phase)
            afd_pkg::PH_HUNT: begin
                if (i_rx_byte == afd_pkg::DELIM) begin
                    n_phase = afd_pkg::PH_LEN_HI;
                end
            end
            afd_pkg::PH_LEN_HI: begin
                n_len_hi = i_rx_byte;
                n_phase  = afd_pkg::PH_LEN_LO;
            end
            afd_pkg::PH_LEN_LO: begin
                n_len   = {r_len_hi, i_rx_byte};
                n_sum   = '0;
                n_idx   = '0;
                n_phase = afd_pkg::PH_BODY;
            end
            afd_pkg::PH_BODY: begin
                n_flen = r_len;
                if (r_idx == IDX_W'(BUF_BYTES)) begin
                    // drop the byte past the buffer end
                    n_status = afd_pkg::ST_OVER;
                    n_phase  = afd_pkg::PH_HUNT;
                end else begin
                    n_sum   = r_sum + i_rx_byte;
                    n_data  = i_rx_byte;
                    n_index = afd_pkg::INDEX_W'(r_idx);
                    if (afd_pkg::LENGTH_W'(r_idx) == r_len) begin
                        n_status = (n_sum == afd_pkg::SUM_GOOD) ? afd_pkg::ST_GOOD
                                                                : afd_pkg::ST_BAD;
                        n_phase  = afd_pkg::PH_HUNT;
                    end else begin
                        n_status = afd_pkg::ST_BODY;
                        n_idx    = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_phase = afd_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rx_acc) begin
            r_len_hi <= n_len_hi;
            r_len    <= n_len;
            r_sum    <= n_sum;
            r_idx    <= n_idx;
            r_status <= n_status;
            r_data   <= n_data;
            r_index  <= n_index;
            r_flen   <= n_flen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (rx_acc) begin
            r_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_res_valid    = r_valid;
    assign o_status       = r_status;
    assign o_data_byte    = r_data;
    assign o_byte_index   = r_index;
    assign o_frame_length = r_flen;

endmodule

// ===== hw/rtl/afd_checker.sv =====
`include "api_frame_deframer_assert.svh"

module afd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_rx_valid,
    input logic                          o_rx_ready,
    input logic [afd_pkg::DATA_W-1:0]    i_rx_byte,
    input logic                          o_res_valid,
    input logic                          i_res_ready,
    input logic [afd_pkg::STATUS_W-1:0]  o_status,
    input logic [afd_pkg::DATA_W-1:0]    o_data_byte,
    input logic [afd_pkg::INDEX_W-1:0]   o_byte_index,
    input logic [afd_pkg::LENGTH_W-1:0]  o_frame_length
);

    logic held_beat;
    logic no_data;
    logic rx_acc;

    assign held_beat = o_res_valid && !i_res_ready;
    assign no_data   = (o_status == afd_pkg::ST_NONE) || (o_status == afd_pkg::ST_OVER);
    assign rx_acc    = i_rx_valid && o_rx_ready;

    `AFD_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, held_beat,
        o_res_valid && $stable(o_status) && $stable(o_data_byte) &&
        $stable(o_byte_index) && $stable(o_frame_length))
    `AFD_ASSERT_NEXT(a_hold_rx, i_clk, i_rst_n, i_rx_valid && !o_rx_ready,
        i_rx_valid && $stable(i_rx_byte))
    `AFD_ASSERT_NEXT(a_one_result, i_clk, i_rst_n, rx_acc, o_res_valid)
    `AFD_ASSERT_NOW(a_ready_when_free, i_clk, i_rst_n, !o_res_valid || i_res_ready, o_rx_ready)
    `AFD_ASSERT_NOW(a_quiet_fields, i_clk, i_rst_n, o_res_valid && no_data,
        (o_data_byte == '0) && (o_byte_index == '0) &&
        ((o_status != afd_pkg::ST_NONE) || (o_frame_length == '0)))

endmodule

bind api_frame_deframer afd_checker u_afd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rx_valid     (i_rx_valid),
    .o_rx_ready     (o_rx_ready),
    .i_rx_byte      (i_rx_byte),
    .o_res_valid    (o_res_valid),
    .i_res_ready    (i_res_ready),
    .o_status       (o_status),
    .o_data_byte    (o_data_byte),
    .o_byte_index   (o_byte_index),
    .o_frame_length (o_frame_length)
);

// ===== sim/api_frame_deframer_tb.sv =====
module api_frame_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BUF_BYTES  = afd_pkg::BUF_BYTES_DEF;
    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned RAND_BEATS = 1600;

    typedef struct packed {
        afd_pkg::t_status                  status;
        logic [afd_pkg::DATA_W-1:0]        data_byte;
        logic [afd_pkg::INDEX_W-1:0]       byte_index;
        logic [afd_pkg::LENGTH_W-1:0]      frame_length;
    } t_deframe_result;

    class frame_tracker;
        int unsigned                       position;
        logic [7:0]                        length_high;
        logic [afd_pkg::LENGTH_W-1:0]      payload_length;
        logic [7:0]                        running_sum;
        t_deframe_result                   awaited[$];
        int unsigned                       errors;

        function new();
            position       = 0;
            length_high    = '0;
            payload_length = '0;
            running_sum    = '0;
            errors         = 0;
        endfunction

        function void take_byte(logic [afd_pkg::DATA_W-1:0] b);
            t_deframe_result r;
            int unsigned     idx;
            r = '{afd_pkg::ST_NONE, '0, '0, '0};
            if (position == 0) begin
                if (b == afd_pkg::DELIM) position = 1;
            end else if (position == 1) begin
                length_high = b;
                position = 2;
            end else if (position == 2) begin
                payload_length = {length_high, b};
                running_sum = '0;
                position = 3;
            end else begin
                idx = position - 3;
                r.frame_length = payload_length;
                if (idx >= BUF_BYTES) begin
                    position = 0;
                    r.status = afd_pkg::ST_OVER;
                end else begin
                    running_sum = running_sum + b;
                    r.data_byte  = b;
                    r.byte_index = idx[afd_pkg::INDEX_W-1:0];
                    if (idx == payload_length) begin
                        position = 0;
                        r.status = (running_sum == afd_pkg::SUM_GOOD) ? afd_pkg::ST_GOOD
                                                                      : afd_pkg::ST_BAD;
                    end else begin
                        position = position + 1;
                        r.status = afd_pkg::ST_BODY;
                    end
                end
            end
            awaited.push_back(r);
        endfunction

        function void check_result(logic [afd_pkg::STATUS_W-1:0] st,
                                   logic [afd_pkg::DATA_W-1:0] d,
                                   logic [afd_pkg::INDEX_W-1:0] idx,
                                   logic [afd_pkg::LENGTH_W-1:0] len);
            t_deframe_result e;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result beat: status %0d data %0h index %0d length %0d",
                         $time, st, d, idx, len);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (st !== e.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, st);
                errors++;
            end
            if (d !== e.data_byte) begin
                $display("%0t: data_byte mismatch: expected %0h, actual %0h",
                         $time, e.data_byte, d);
                errors++;
            end
            if (idx !== e.byte_index) begin
                $display("%0t: byte_index mismatch: expected %0d, actual %0d",
                         $time, e.byte_index, idx);
                errors++;
            end
            if (len !== e.frame_length) begin
                $display("%0t: frame_length mismatch: expected %0d, actual %0d",
                         $time, e.frame_length, len);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_rx_valid = 1'b0;
    logic [afd_pkg::DATA_W-1:0]        i_rx_byte = '0;
    logic                              i_res_ready = 1'b0;
    logic                              o_rx_ready;
    logic                              o_res_valid;
    logic [afd_pkg::STATUS_W-1:0]      o_status;
    logic [afd_pkg::DATA_W-1:0]        o_data_byte;
    logic [afd_pkg::INDEX_W-1:0]       o_byte_index;
    logic [afd_pkg::LENGTH_W-1:0]      o_frame_length;

    frame_tracker tracker = new();
    int unsigned  burst_left = 0;
    int unsigned  beats_sent = 0;
    int unsigned  idle_cycles = 0;
    logic [7:0]   ready_pattern = 8'hFF;
    int unsigned  pattern_age = 0;

    api_frame_deframer #(
        .BUF_BYTES(BUF_BYTES)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_status       (o_status),
        .o_data_byte    (o_data_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_length (o_frame_length)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver stalls on a rotating pattern, replaced by a new random or all-ready one when its age runs out
    always @(posedge i_clk) begin
        if (pattern_age == 0) begin
            pattern_age <= $urandom_range(20, 80);
            if ($urandom_range(0, 2) == 0) begin
                ready_pattern <= 8'hFF;
            end else begin
                ready_pattern <= 8'($urandom_range(1, 255));
            end
        end else begin
            pattern_age <= pattern_age - 1;
        end
        i_res_ready <= i_rst_n ? ready_pattern[pattern_age[2:0]] : 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_rx_valid && o_rx_ready) tracker.take_byte(i_rx_byte);
            if (o_res_valid && i_res_ready)
                tracker.check_result(o_status, o_data_byte, o_byte_index, o_frame_length);
            if ((i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles == IDLE_LIMIT) begin
            $display("api_frame_deframer_tb: done, errors");
            $finish;
        end
    end

    task automatic send_byte(input logic [afd_pkg::DATA_W-1:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        beats_sent++;
    endtask

    // send header and body; below BUF_BYTES a checksum byte follows, made good unless corrupt is set
    task automatic send_frame(input logic [afd_pkg::LENGTH_W-1:0] len, input bit corrupt);
        logic [7:0]  sum;
        logic [7:0]  b;
        int unsigned body;
        sum = '0;
        send_byte(afd_pkg::DELIM);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        body = (len >= BUF_BYTES) ? BUF_BYTES + 1 : len;
        for (int unsigned i = 0; i < body; i++) begin
            b = 8'($urandom_range(0, 255));
            sum = sum + b;
            send_byte(b);
        end
        if (len < BUF_BYTES) begin
            b = afd_pkg::SUM_GOOD - sum;
            if (corrupt) b = b ^ 8'($urandom_range(1, 255));
            send_byte(b);
        end
    endtask

    initial begin
        logic [afd_pkg::LENGTH_W-1:0] len;
        int unsigned                  pick;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(afd_pkg::DELIM); send_byte(8'h00); send_byte(8'h00); send_byte(8'hFF);
        send_byte(afd_pkg::DELIM); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        send_byte(afd_pkg::DELIM); send_byte(8'h00); send_byte(8'h02);
        send_byte(afd_pkg::DELIM); send_byte(8'h81); send_byte(8'h00);
        send_byte(afd_pkg::DELIM); send_byte(8'h00); send_byte(8'h01);
        send_byte(8'hFF); send_byte(8'h01);
        send_byte(afd_pkg::DELIM); send_byte(afd_pkg::DELIM); send_byte(8'h00);
        send_byte(8'h42);

        while (beats_sent < RAND_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 14) begin
                len = 16'($urandom_range(0, 65535));
                if (len < BUF_BYTES) len[15] = 1'b1;
                send_frame(len, 1'b0);
            end else if (pick < 18) begin
                send_frame(16'(BUF_BYTES - 1 - $urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            end else if (pick < 24) begin
                // truncated frame: the next delimiter lands in its body
                send_byte(afd_pkg::DELIM);
                send_byte(8'h00);
                send_byte(8'($urandom_range(4, 20)));
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_frame(16'($urandom_range(0, 12)), $urandom_range(0, 4) == 0);
            end
        end
        i_rx_valid <= 1'b0;

        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("api_frame_deframer_tb: done, clean");
        end else begin
            $display("api_frame_deframer_tb: done, errors");
        end
        $finish;
    end
endmodule

// ===== api_frame_deframer.f =====
+incdir+hw/rtl
hw/rtl/afd_pkg.sv
hw/rtl/api_frame_deframer.sv
hw/rtl/afd_checker.sv
sim/api_frame_deframer_tb.sv
